// ===== sv/scsp_pkg.sv =====
// Shared types, codes and constants of the S-curve step-rate profiler.
// Also holds the elaboration-time functions that build the shape table.
// No dependencies.
package scsp_pkg;

  localparam int RATE_W    = 32;
  localparam int TICK_W    = 16;
  localparam int CMD_W     = 2;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [RATE_W-1:0] BASE_RATE_RST   = 32'd1;
  localparam logic [RATE_W-1:0] PEAK_RATE_RST   = 32'd1;
  localparam logic [RATE_W-1:0] MAX_RATE_RST    = 32'hFFFF_FFFF;
  localparam logic [TICK_W-1:0] ACCEL_TICKS_RST = 16'd1;
  localparam logic [RATE_W-1:0] DECEL_REM_RST   = 32'd0;

  // Fixed-point constants for the cosine series, Q60.
  localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TWO_Q60      = 64'h2000_0000_0000_0000;
  localparam logic [63:0] PI_Q60       = 64'h3243_F6A8_885A_308D;
  localparam int          SERIES_TERMS = 12;
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RATE       = 3'd0,
    REG_PEAK_RATE       = 3'd1,
    REG_MAX_RATE        = 3'd2,
    REG_ACCEL_TICKS     = 3'd3,
    REG_DECEL_REMAINING = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [RATE_W-1:0] remaining_steps;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_word;
    logic [PHASE_W-1:0] phase_now;
  } result_t;

  typedef enum logic [1:0] {
    EL_KEEP,
    EL_CLEAR,
    EL_BUMP
  } el_op_t;

  typedef enum logic [1:0] {
    V_BASE,
    V_PEAK,
    V_UP,
    V_DN
  } v_sel_t;

  typedef enum logic {
    DIV_POS,
    DIV_FRAC
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV1,
    S_RD_LO,
    S_RD_HI,
    S_MUL_D,
    S_DIV2_GO,
    S_DIV2_W,
    S_MUL_S,
    S_APPLY,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     ld_item;
    logic     phase_ld;
    phase_t   phase_val;
    el_op_t   el_op;
    logic     v_ld;
    v_sel_t   v_sel;
    logic     div_go;
    div_sel_t div_sel;
    logic     save_div;
    logic     rom_hi;
    logic     lo_ld;
    logic     prod_ld;
    logic     s_ld;
    logic     off_ld;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    phase_t           phase;
    logic             sat;
    logic             decel_hit;
    logic             rem_zero;
    logic             peak_gt_base;
    logic             div_busy;
  } dp_status_t;

  // Q60 product, truncated.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // One entry of (1-cos(theta))/2 in Q(frac_bits), theta in Q60, for the
  // first half of the table. Evaluated only at elaboration.
  function automatic logic [31:0] shape_half(input logic [63:0] theta, input int frac_bits);
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] cosv;
    logic [63:0] f;
    logic [63:0] rnd;
    t    = mul_q60(theta, theta);
    term = ONE_Q60;
    cosv = ONE_Q60;
    for (int k = 0; k < SERIES_TERMS; k++) begin
      term = mul_q60(term, t) / SERIES_DIV[k];
      if (k[0] == 1'b0) begin
        cosv = cosv - term;
      end else begin
        cosv = cosv + term;
      end
    end
    if (cosv > TWO_Q60) begin
      cosv = 64'd0;
    end else if (cosv > ONE_Q60) begin
      cosv = ONE_Q60;
    end
    f   = (ONE_Q60 - cosv) >> 1;
    rnd = 64'd1 << (59 - frac_bits);
    return 32'((f + rnd) >> (60 - frac_bits));
  endfunction

endpackage

// ===== sv/scsp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on scsp_pkg for the tick width.
module scsp_div #(
  parameter int LW = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [scsp_pkg::TICK_W-1:0]    p_init,
  input  logic [LW-1:0]                  low_init,
  input  logic [$clog2(LW+1)-1:0]        nbits,
  input  logic [scsp_pkg::TICK_W-1:0]    divisor,
  output logic                           busy,
  output logic [LW-1:0]                  quot,
  output logic [scsp_pkg::TICK_W-1:0]    rem
);

  localparam int CW = $clog2(LW + 1);
  localparam int TW = scsp_pkg::TICK_W;

  logic [CW-1:0] cnt;
  logic [TW-1:0] p;
  logic [LW-1:0] low;
  logic [LW-1:0] q;
  logic [TW:0]   trial;
  logic [TW:0]   diff;
  logic          ge;

  // The partial remainder stays below the divisor, so after the shift it
  // is below twice the divisor and one subtract settles the bit.
  assign trial = {p, low[LW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= nbits;
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      p   <= p_init;
      low <= low_init;
      q   <= '0;
    end else if (cnt != '0) begin
      p   <= ge ? diff[TW-1:0] : trial[TW-1:0];
      low <= {low[LW-2:0], 1'b0};
      q   <= {q[LW-2:0], ge};
    end
  end

  assign busy = cnt != '0;
  assign quot = q;
  assign rem  = p;

endmodule

// ===== sv/scsp_dp.sv =====
// Datapath of the profiler: registers, shape table, multipliers and divider.
// Depends on scsp_pkg and scsp_div; driven by scsp_ctrl commands.
module scsp_dp #(
  parameter int TABLE_SIZE = scsp_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = scsp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scsp_pkg::RATE_W-1:0]      cfg_data,
  input  scsp_pkg::item_t                  item,
  input  scsp_pkg::dp_cmd_t                ctl,
  output scsp_pkg::dp_status_t             st,
  output scsp_pkg::result_t                result
);

  localparam int RW = scsp_pkg::RATE_W;
  localparam int TW = scsp_pkg::TICK_W;
  localparam int TB = $clog2(TABLE_SIZE);
  localparam int AW = $clog2(TABLE_SIZE + 1);
  localparam int SW = FRAC_BITS + 1;
  localparam int NW = TW + TB;
  localparam int LW = (TB > SW) ? TB : SW;
  localparam int CW = $clog2(LW + 1);
  localparam int PW = SW + TW;
  localparam int MW = RW + SW;
  localparam logic [63:0] PI_QUO = scsp_pkg::PI_Q60 / TABLE_SIZE;
  localparam logic [63:0] PI_REM = scsp_pkg::PI_Q60 % TABLE_SIZE;
  localparam logic [31:0] FULL   = 32'd1 << FRAC_BITS;

  // Configuration registers.
  logic [RW-1:0] base_rate;
  logic [RW-1:0] peak_rate;
  logic [RW-1:0] max_rate;
  logic [TW-1:0] accel_ticks;
  logic [RW-1:0] decel_remaining;

  scsp_pkg::phase_t phase;
  logic [TW-1:0]    elapsed;
  scsp_pkg::item_t  item_q;

  logic [AW-1:0] k_q;
  logic [TW-1:0] r_q;
  logic [SW-1:0] rom_q;
  logic [SW-1:0] lo_q;
  logic [PW-1:0] prod_q;
  logic [SW-1:0] s_q;
  logic [RW-1:0] off_q;
  logic [RW-1:0] v_q;

  logic [RW-1:0] peak_eff;
  logic [RW-1:0] span;
  logic [TW-1:0] tk;
  logic [TW-1:0] el_new;
  logic [NW-1:0] n;
  logic [AW-1:0] rom_addr;
  logic [SW-1:0] shape_rom [TABLE_SIZE+1];
  logic [MW-1:0] off_full;
  logic [RW-1:0] v_lo;
  logic [RW-1:0] v_hi;
  logic [RW-1:0] v_clamped;

  logic [TW-1:0] div_p;
  logic [LW-1:0] div_low;
  logic [CW-1:0] div_nbits;
  logic          div_busy;
  logic [LW-1:0] div_quot;
  logic [TW-1:0] div_rem;

  // Shape table, mirrored about its midpoint.
  for (genvar g = 0; g <= TABLE_SIZE; g++) begin : g_shape
    localparam int          MIR   = (g <= TABLE_SIZE / 2) ? g : TABLE_SIZE - g;
    localparam logic [63:0] THETA = PI_QUO * MIR + (PI_REM * MIR) / TABLE_SIZE;
    localparam logic [31:0] HALF  = scsp_pkg::shape_half(THETA, FRAC_BITS);
    localparam logic [31:0] ENTRY = (g <= TABLE_SIZE / 2) ? HALF : FULL - HALF;
    assign shape_rom[g] = ENTRY[SW-1:0];
  end

  assign peak_eff = (peak_rate < base_rate) ? base_rate : peak_rate;
  assign span     = peak_eff - base_rate;
  assign tk       = (accel_ticks == '0) ? TW'(1) : accel_ticks;
  assign el_new   = (elapsed == '1) ? elapsed : elapsed + TW'(1);
  assign n        = NW'(el_new) * NW'(TABLE_SIZE);
  assign rom_addr = ctl.rom_hi ? k_q + AW'(1) : k_q;

  always_comb begin
    st.cmd          = item_q.cmd;
    st.phase        = phase;
    st.sat          = el_new >= tk;
    st.decel_hit    = (item_q.remaining_steps != '0) &&
                      (item_q.remaining_steps <= decel_remaining);
    st.rem_zero     = item_q.remaining_steps == '0;
    st.peak_gt_base = peak_rate > base_rate;
    st.div_busy     = div_busy;
  end

  // Both divisions have a quotient known to fit the bit count, so the
  // upper dividend bits already sit below the divisor.
  always_comb begin
    if (ctl.div_sel == scsp_pkg::DIV_POS) begin
      div_p     = n[NW-1:TB];
      div_low   = LW'(n[TB-1:0]) << (LW - TB);
      div_nbits = CW'(TB);
    end else begin
      div_p     = prod_q[PW-1:SW];
      div_low   = LW'(prod_q[SW-1:0]) << (LW - SW);
      div_nbits = CW'(SW);
    end
  end

  scsp_div #(
    .LW(LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctl.div_go),
    .p_init   (div_p),
    .low_init (div_low),
    .nbits    (div_nbits),
    .divisor  (tk),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate       <= scsp_pkg::BASE_RATE_RST;
      peak_rate       <= scsp_pkg::PEAK_RATE_RST;
      max_rate        <= scsp_pkg::MAX_RATE_RST;
      accel_ticks     <= scsp_pkg::ACCEL_TICKS_RST;
      decel_remaining <= scsp_pkg::DECEL_REM_RST;
    end else if (cfg_we) begin
      unique case (scsp_pkg::cfg_reg_t'(cfg_index))
        scsp_pkg::REG_BASE_RATE:       base_rate       <= cfg_data;
        scsp_pkg::REG_PEAK_RATE:       peak_rate       <= cfg_data;
        scsp_pkg::REG_MAX_RATE:        max_rate        <= cfg_data;
        scsp_pkg::REG_ACCEL_TICKS:     accel_ticks     <= cfg_data[TW-1:0];
        scsp_pkg::REG_DECEL_REMAINING: decel_remaining <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= scsp_pkg::PH_IDLE;
      elapsed <= '0;
    end else begin
      if (ctl.phase_ld) begin
        phase <= ctl.phase_val;
      end
      case (ctl.el_op)
        scsp_pkg::EL_CLEAR: elapsed <= '0;
        scsp_pkg::EL_BUMP:  elapsed <= el_new;
        default:            elapsed <= elapsed;
      endcase
    end
  end

  assign off_full = MW'(span) * MW'(s_q);

  always_ff @(posedge clk) begin
    rom_q <= shape_rom[rom_addr];
    if (ctl.ld_item) begin
      item_q <= item;
    end
    if (ctl.save_div) begin
      k_q <= AW'(div_quot[TB-1:0]);
      r_q <= div_rem;
    end
    if (ctl.lo_ld) begin
      lo_q <= rom_q;
    end
    if (ctl.prod_ld) begin
      prod_q <= PW'(rom_q - lo_q) * PW'(r_q);
    end
    if (ctl.s_ld) begin
      s_q <= lo_q + div_quot[SW-1:0];
    end
    if (ctl.off_ld) begin
      off_q <= off_full[FRAC_BITS +: RW];
    end
    if (ctl.v_ld) begin
      case (ctl.v_sel)
        scsp_pkg::V_BASE: v_q <= base_rate;
        scsp_pkg::V_PEAK: v_q <= peak_eff;
        scsp_pkg::V_UP:   v_q <= base_rate + off_q;
        default:          v_q <= peak_eff - off_q;
      endcase
    end
    if (ctl.out_ld) begin
      result.rate_word <= v_clamped;
      result.phase_now <= phase;
    end
  end

  // Raise to base, lower to the ceiling, and never emit a zero rate.
  always_comb begin
    v_lo      = (v_q < base_rate) ? base_rate : v_q;
    v_hi      = (v_lo > max_rate) ? max_rate : v_lo;
    v_clamped = (v_hi == '0) ? RW'(1) : v_hi;
  end

endmodule

// ===== sv/scsp_ctrl.sv =====
// Controller state machine of the profiler: handshakes and step sequencing.
// Depends on scsp_pkg; commands scsp_dp through a command struct.
module scsp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  scsp_pkg::dp_status_t  st,
  output scsp_pkg::dp_cmd_t     ctl
);

  scsp_pkg::ctrl_state_t state;
  scsp_pkg::ctrl_state_t state_next;
  logic                  dir_down;
  logic                  dir_down_next;
  logic                  slot_free;

  assign slot_free  = !result_valid || !result_stall;
  assign item_stall = state != scsp_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= scsp_pkg::S_IDLE;
      dir_down     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      dir_down <= dir_down_next;
      if (ctl.out_ld) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    dir_down_next = dir_down;
    unique case (state)
      scsp_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = scsp_pkg::S_DECODE;
        end
      end
      scsp_pkg::S_DECODE: begin
        dir_down_next = st.phase == scsp_pkg::PH_DECEL;
        unique case (st.cmd)
          scsp_pkg::CMD_START: state_next = scsp_pkg::S_EMIT;
          scsp_pkg::CMD_TICK: begin
            unique case (st.phase)
              scsp_pkg::PH_ACCEL:
                state_next = (st.decel_hit || st.sat) ? scsp_pkg::S_EMIT : scsp_pkg::S_DIV1;
              scsp_pkg::PH_CRUISE:
                state_next = scsp_pkg::S_EMIT;
              scsp_pkg::PH_DECEL:
                state_next = st.sat ? scsp_pkg::S_EMIT : scsp_pkg::S_DIV1;
              default:
                state_next = scsp_pkg::S_IDLE;
            endcase
          end
          default: state_next = scsp_pkg::S_IDLE;
        endcase
      end
      scsp_pkg::S_DIV1: begin
        if (!st.div_busy) begin
          state_next = scsp_pkg::S_RD_LO;
        end
      end
      scsp_pkg::S_RD_LO:   state_next = scsp_pkg::S_RD_HI;
      scsp_pkg::S_RD_HI:   state_next = scsp_pkg::S_MUL_D;
      scsp_pkg::S_MUL_D:   state_next = scsp_pkg::S_DIV2_GO;
      scsp_pkg::S_DIV2_GO: state_next = scsp_pkg::S_DIV2_W;
      scsp_pkg::S_DIV2_W: begin
        if (!st.div_busy) begin
          state_next = scsp_pkg::S_MUL_S;
        end
      end
      scsp_pkg::S_MUL_S: state_next = scsp_pkg::S_APPLY;
      scsp_pkg::S_APPLY: state_next = scsp_pkg::S_EMIT;
      scsp_pkg::S_EMIT: begin
        if (slot_free) begin
          state_next = scsp_pkg::S_IDLE;
        end
      end
      default: state_next = scsp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      scsp_pkg::S_IDLE: begin
        ctl.ld_item = item_valid;
      end
      scsp_pkg::S_DECODE: begin
        unique case (st.cmd)
          scsp_pkg::CMD_START: begin
            ctl.phase_ld  = 1'b1;
            ctl.phase_val = st.peak_gt_base ? scsp_pkg::PH_ACCEL : scsp_pkg::PH_CRUISE;
            ctl.el_op     = scsp_pkg::EL_CLEAR;
            ctl.v_ld      = 1'b1;
            ctl.v_sel     = scsp_pkg::V_BASE;
          end
          scsp_pkg::CMD_STOP: begin
            ctl.phase_ld  = 1'b1;
            ctl.phase_val = scsp_pkg::PH_IDLE;
            ctl.el_op     = scsp_pkg::EL_CLEAR;
          end
          scsp_pkg::CMD_TICK: begin
            unique case (st.phase)
              scsp_pkg::PH_ACCEL: begin
                ctl.el_op = scsp_pkg::EL_BUMP;
                // Reaching the decel point overrides the end of the ramp.
                if (st.decel_hit) begin
                  ctl.phase_ld  = 1'b1;
                  ctl.phase_val = scsp_pkg::PH_DECEL;
                  ctl.el_op     = scsp_pkg::EL_CLEAR;
                  ctl.v_ld      = 1'b1;
                  ctl.v_sel     = scsp_pkg::V_PEAK;
                end else if (st.sat) begin
                  ctl.phase_ld  = 1'b1;
                  ctl.phase_val = scsp_pkg::PH_CRUISE;
                  ctl.v_ld      = 1'b1;
                  ctl.v_sel     = scsp_pkg::V_PEAK;
                end else begin
                  ctl.div_go  = 1'b1;
                  ctl.div_sel = scsp_pkg::DIV_POS;
                end
              end
              scsp_pkg::PH_CRUISE: begin
                ctl.v_ld  = 1'b1;
                ctl.v_sel = scsp_pkg::V_PEAK;
                if (st.decel_hit) begin
                  ctl.phase_ld  = 1'b1;
                  ctl.phase_val = scsp_pkg::PH_DECEL;
                  ctl.el_op     = scsp_pkg::EL_CLEAR;
                end
              end
              scsp_pkg::PH_DECEL: begin
                ctl.el_op = scsp_pkg::EL_BUMP;
                if (st.rem_zero) begin
                  ctl.phase_ld  = 1'b1;
                  ctl.phase_val = scsp_pkg::PH_DONE;
                end
                if (st.sat) begin
                  ctl.v_ld  = 1'b1;
                  ctl.v_sel = scsp_pkg::V_BASE;
                end else begin
                  ctl.div_go  = 1'b1;
                  ctl.div_sel = scsp_pkg::DIV_POS;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      scsp_pkg::S_DIV1: begin
        ctl.save_div = !st.div_busy;
      end
      scsp_pkg::S_RD_LO: ;
      scsp_pkg::S_RD_HI: begin
        ctl.lo_ld  = 1'b1;
        ctl.rom_hi = 1'b1;
      end
      scsp_pkg::S_MUL_D: begin
        ctl.prod_ld = 1'b1;
      end
      scsp_pkg::S_DIV2_GO: begin
        ctl.div_go  = 1'b1;
        ctl.div_sel = scsp_pkg::DIV_FRAC;
      end
      scsp_pkg::S_DIV2_W: begin
        ctl.div_sel = scsp_pkg::DIV_FRAC;
        ctl.s_ld    = !st.div_busy;
      end
      scsp_pkg::S_MUL_S: begin
        ctl.off_ld = 1'b1;
      end
      scsp_pkg::S_APPLY: begin
        ctl.v_ld  = 1'b1;
        ctl.v_sel = dir_down ? scsp_pkg::V_DN : scsp_pkg::V_UP;
      end
      scsp_pkg::S_EMIT: begin
        ctl.out_ld = slot_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/s_curve_step_rate_profiler_core.sv =====
// Raised-cosine S-curve step-rate profiler, top level.
// Start and non-interpolated ticks go through decode and emit; stop, and ticks in the
// idle or done phase, emit no result. Interpolated ticks divide, read two entries,
// multiply, divide again, scale and apply; the bit-serial divider runs twice per tick.
// One item at a time; the next is taken once the result sits in the output register.
// Synchronous reset loads the register defaults, phase idle and elapsed ticks zero.
module s_curve_step_rate_profiler_core #(
  parameter int TABLE_SIZE = scsp_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = scsp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  scsp_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output scsp_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scsp_pkg::RATE_W-1:0]     cfg_data
);

  scsp_pkg::dp_cmd_t    ctl;
  scsp_pkg::dp_status_t st;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  scsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .ctl          (ctl)
  );

  scsp_dp #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .ctl       (ctl),
    .st        (st),
    .result    (result)
  );

endmodule
